[design/msi_interrupt_translation_service_defines.svh]
// Assertion macros for the interrupt translation service.
// Included by the top level; no other dependencies.
`ifndef MSI_INTERRUPT_TRANSLATION_SERVICE_DEFINES_SVH
`define MSI_INTERRUPT_TRANSLATION_SERVICE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define MSITS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MSITS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/msits_pkg.sv]
// Shared types and constants of the interrupt translation service.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package msits_pkg;

    localparam logic [3:0] OP_TRANSLATE  = 4'h0;
    localparam logic [3:0] OP_MOVI       = 4'h1;
    localparam logic [3:0] OP_SYNC       = 4'h5;
    localparam logic [3:0] OP_MAPD       = 4'h8;
    localparam logic [3:0] OP_MAPC       = 4'h9;
    localparam logic [3:0] OP_MAP_INTID  = 4'ha;
    localparam logic [3:0] OP_INV        = 4'hc;
    localparam logic [3:0] OP_INV_COLL   = 4'hd;
    localparam logic [3:0] OP_DROP_EVENT = 4'hf;

    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_DISABLED = 3'd1;
    localparam logic [2:0] STS_NODEV    = 3'd2;
    localparam logic [2:0] STS_RANGE    = 3'd3;
    localparam logic [2:0] STS_NOEVENT  = 3'd4;
    localparam logic [2:0] STS_NOCOL    = 3'd5;
    localparam logic [2:0] STS_BADOP    = 3'd6;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DEV,
        S_EVT,
        S_COL,
        S_SWEEP,
        S_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic dev_chk;
        logic col_rd;
        logic commit;
        logic cnt_clr;
        logic init_step;
        logic sweep_step;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic init_last;
        logic sweep_last;
        logic mapd_go;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

[design/msits_ctrl.sv]
// Sequencer of the interrupt translation service: clear, lookup chain, sweep, output.
// Depends on msits_pkg for the state, command and status types.
`default_nettype none

module msits_ctrl
    import msits_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_in_stall
);

    t_state r_state;
    t_state n_state;
    logic   ready;
    logic   accept;

    assign ready  = (r_state == S_IDLE) || ((r_state == S_OUT) && i_stat.out_free);
    assign accept = i_in_valid && ready;
    assign o_in_stall = !ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (i_stat.init_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) n_state = S_DEV;
            end
            S_DEV:  n_state = S_EVT;
            S_EVT:  n_state = S_COL;
            S_COL: begin
                n_state = i_stat.mapd_go ? S_SWEEP : S_OUT;
            end
            S_SWEEP: begin
                if (i_stat.sweep_last) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) n_state = accept ? S_DEV : S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.accept     = accept;
        case (r_state)
            S_INIT:  o_cmd.init_step = 1'b1;
            S_DEV:   o_cmd.dev_chk = 1'b1;
            S_EVT:   o_cmd.col_rd = 1'b1;
            S_COL: begin
                o_cmd.commit  = 1'b1;
                o_cmd.cnt_clr = 1'b1;
            end
            S_SWEEP: o_cmd.sweep_step = 1'b1;
            S_OUT:   o_cmd.out_load = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

[design/msits_dpath.sv]
// Datapath of the interrupt translation service: the device, event and collection
// tables, the item and result registers, the sweep counter. Depends on msits_pkg.
`default_nettype none

module msits_dpath
    import msits_pkg::*;
#(
    parameter int DEVICES     = 64,
    parameter int EVENTS      = 64,
    parameter int COLLECTIONS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire  [3:0]  i_operation,
    input  wire  [5:0]  i_device_id,
    input  wire  [5:0]  i_event_id,
    input  wire  [15:0] i_lpi_intid,
    input  wire  [3:0]  i_collection,
    input  wire  [15:0] i_rd_target,
    input  wire         i_map_valid,
    input  wire  [2:0]  i_itt_event_bits,
    input  wire         i_cfg_valid,
    input  wire         i_cfg_data,
    input  wire         i_out_stall,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic        o_out_valid,
    output logic [2:0]  o_status,
    output logic [15:0] o_out_intid,
    output logic [15:0] o_out_target
);

    localparam int EV_DEPTH = DEVICES * EVENTS;
    localparam int CLR_LEN  = (EV_DEPTH > COLLECTIONS) ? EV_DEPTH : COLLECTIONS;
    localparam int DEV_W    = $clog2(DEVICES);
    localparam int EI_W     = $clog2(EV_DEPTH);
    localparam int COL_W    = (COLLECTIONS > 1) ? $clog2(COLLECTIONS) : 1;
    localparam int CNT_W    = $clog2(CLR_LEN);
    localparam int EV_W     = 1 + 16 + COL_W;

    // Tables
    logic [3:0]      r_dev_mem [DEVICES];
    logic [EV_W-1:0] r_evt_mem [EV_DEPTH];
    logic [16:0]     r_col_mem [COLLECTIONS];

    logic [3:0]      r_dev_q;
    logic [EV_W-1:0] r_ev_q;
    logic [16:0]     r_col_q;

    // Item under work
    logic [3:0]  r_op;
    logic [5:0]  r_dev;
    logic [5:0]  r_evt;
    logic [15:0] r_intid;
    logic [3:0]  r_col;
    logic [15:0] r_target;
    logic        r_mvalid;
    logic [2:0]  r_ebits;

    logic            r_its_enabled;
    logic [2:0]      r_loc;
    logic            r_dev_in;
    logic [EI_W-1:0] r_ebase;
    logic [EI_W-1:0] r_eaddr;
    logic [CNT_W-1:0] r_cnt;

    logic [2:0]  r_res_status;
    logic [15:0] r_res_intid;
    logic [15:0] r_res_target;
    logic        r_out_valid;

    logic            dev_in;
    logic            evt_in;
    logic            col_in;
    logic [2:0]      n_loc;
    logic [EI_W-1:0] n_ebase;
    logic [EI_W-1:0] n_eaddr;
    logic            ev_valid;
    logic [15:0]     ev_intid;
    logic [COL_W-1:0] ev_icid;
    logic [2:0]      n_status;
    logic [15:0]     n_intid;
    logic [15:0]     n_target;

    logic            evt_we;
    logic [EI_W-1:0] evt_wa;
    logic [EV_W-1:0] evt_wd;
    logic            dev_we;
    logic [DEV_W-1:0] dev_wa;
    logic [3:0]      dev_wd;
    logic            col_we;
    logic [COL_W-1:0] col_wa;
    logic [16:0]     col_wd;

    assign ev_valid = r_ev_q[EV_W-1];
    assign ev_intid = r_ev_q[EV_W-2 -: 16];
    assign ev_icid  = r_ev_q[COL_W-1:0];

    // Device and event range lookup
    always_comb begin
        dev_in  = 32'(r_dev) < DEVICES;
        evt_in  = (32'(r_evt) < EVENTS) && ((r_evt >> r_dev_q[2:0]) == 6'd0);
        n_ebase = EI_W'(DEV_W'(r_dev)) * EI_W'(EVENTS);
        n_eaddr = n_ebase + EI_W'(r_evt);
        if (!dev_in || !r_dev_q[3]) begin
            n_loc = STS_NODEV;
        end else if (!evt_in) begin
            n_loc = STS_RANGE;
        end else begin
            n_loc = STS_OK;
        end
        col_in = 32'(r_col) < COLLECTIONS;
    end

    // Final status of the item
    always_comb begin
        n_status = STS_OK;
        n_intid  = '0;
        n_target = '0;
        if (!r_its_enabled) begin
            n_status = STS_DISABLED;
        end else begin
            case (r_op)
                OP_TRANSLATE: begin
                    if (r_loc != STS_OK) n_status = r_loc;
                    else if (!ev_valid) n_status = STS_NOEVENT;
                    else if (!r_col_q[16]) n_status = STS_NOCOL;
                    else begin
                        n_intid  = ev_intid;
                        n_target = r_col_q[15:0];
                    end
                end
                OP_MAPD: begin
                    if (!r_dev_in) n_status = STS_NODEV;
                end
                OP_MAPC, OP_INV_COLL: begin
                    if (!col_in) n_status = STS_NOCOL;
                end
                OP_MAP_INTID: begin
                    if (r_loc != STS_OK) n_status = r_loc;
                    else if (!col_in) n_status = STS_NOCOL;
                end
                OP_MOVI: begin
                    if (r_loc != STS_OK) n_status = r_loc;
                    else if (!ev_valid) n_status = STS_NOEVENT;
                    else if (!col_in) n_status = STS_NOCOL;
                end
                OP_DROP_EVENT, OP_INV: begin
                    if (r_loc != STS_OK) n_status = r_loc;
                    else if (!ev_valid) n_status = STS_NOEVENT;
                end
                OP_SYNC: n_status = STS_OK;
                default: n_status = STS_BADOP;
            endcase
        end
    end

    // Table write ports
    always_comb begin
        evt_we = 1'b0;
        evt_wa = r_eaddr;
        evt_wd = '0;
        dev_we = 1'b0;
        dev_wa = DEV_W'(r_dev);
        dev_wd = {r_mvalid, (r_ebits == 3'd0) ? 3'd1 : r_ebits};
        col_we = 1'b0;
        col_wa = COL_W'(r_col);
        col_wd = {r_mvalid, r_mvalid ? r_target : 16'd0};
        if (i_cmd.init_step) begin
            evt_we = 32'(r_cnt) < EV_DEPTH;
            evt_wa = EI_W'(r_cnt);
            dev_we = 32'(r_cnt) < DEVICES;
            dev_wa = DEV_W'(r_cnt);
            dev_wd = '0;
            col_we = 32'(r_cnt) < COLLECTIONS;
            col_wa = COL_W'(r_cnt);
            col_wd = '0;
        end else if (i_cmd.sweep_step) begin
            evt_we = 1'b1;
            evt_wa = r_ebase + EI_W'(r_cnt);
        end else if (i_cmd.commit && (n_status == STS_OK) && r_its_enabled) begin
            case (r_op)
                OP_MAP_INTID: begin
                    evt_we = 1'b1;
                    evt_wd = {1'b1, r_intid, COL_W'(r_col)};
                end
                OP_MOVI: begin
                    evt_we = 1'b1;
                    evt_wd = {1'b1, ev_intid, COL_W'(r_col)};
                end
                OP_DROP_EVENT: evt_we = 1'b1;
                OP_MAPD:       dev_we = 1'b1;
                OP_MAPC:       col_we = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (dev_we) r_dev_mem[dev_wa] <= dev_wd;
        if (i_cmd.accept && (32'(i_device_id) < DEVICES)) begin
            r_dev_q <= r_dev_mem[DEV_W'(i_device_id)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (evt_we) r_evt_mem[evt_wa] <= evt_wd;
        if (i_cmd.dev_chk && (n_loc == STS_OK)) r_ev_q <= r_evt_mem[n_eaddr];
    end

    always_ff @(posedge i_clk) begin
        if (col_we) r_col_mem[col_wa] <= col_wd;
        if (i_cmd.col_rd && (r_loc == STS_OK) && ev_valid) r_col_q <= r_col_mem[ev_icid];
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= i_operation;
            r_dev    <= i_device_id;
            r_evt    <= i_event_id;
            r_intid  <= i_lpi_intid;
            r_col    <= i_collection;
            r_target <= i_rd_target;
            r_mvalid <= i_map_valid;
            r_ebits  <= i_itt_event_bits;
        end
        if (i_cmd.dev_chk) begin
            r_loc    <= n_loc;
            r_dev_in <= dev_in;
            r_ebase  <= n_ebase;
            r_eaddr  <= n_eaddr;
        end
        if (i_cmd.commit) begin
            r_res_status <= n_status;
            r_res_intid  <= n_intid;
            r_res_target <= n_target;
        end
        if (i_cmd.out_load) begin
            o_status     <= r_res_status;
            o_out_intid  <= r_res_intid;
            o_out_target <= r_res_target;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_its_enabled <= 1'b0;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) r_its_enabled <= i_cfg_data;
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.init_step || i_cmd.sweep_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_stat.init_last  = (r_cnt == CNT_W'(CLR_LEN - 1));
    assign o_stat.sweep_last = (r_cnt == CNT_W'(EVENTS - 1));
    assign o_stat.mapd_go    = (r_op == OP_MAPD) && (n_status == STS_OK);
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

endmodule

`default_nettype wire

[design/msi_interrupt_translation_service.sv]
// Interrupt translation service top level: controller plus table datapath.
// Each item passes the chained device, event and collection table reads in turn; a new
// item is taken only as the previous result is loaded into the output registers. MAPD
// then sweeps the device's event entries clear. After reset the tables are cleared while
// input stays stalled.
`default_nettype none

module msi_interrupt_translation_service
    import msits_pkg::*;
#(
    parameter int DEVICES     = 64,
    parameter int EVENTS      = 64,
    parameter int COLLECTIONS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [3:0]  i_operation,
    input  wire  [5:0]  i_device_id,
    input  wire  [5:0]  i_event_id,
    input  wire  [15:0] i_lpi_intid,
    input  wire  [3:0]  i_collection,
    input  wire  [15:0] i_rd_target,
    input  wire         i_map_valid,
    input  wire  [2:0]  i_itt_event_bits,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_out_intid,
    output logic [15:0] o_out_target,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_data
);

    `include "msi_interrupt_translation_service_defines.svh"

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    msits_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    msits_dpath #(
        .DEVICES     (DEVICES),
        .EVENTS      (EVENTS),
        .COLLECTIONS (COLLECTIONS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_operation      (i_operation),
        .i_device_id      (i_device_id),
        .i_event_id       (i_event_id),
        .i_lpi_intid      (i_lpi_intid),
        .i_collection     (i_collection),
        .i_rd_target      (i_rd_target),
        .i_map_valid      (i_map_valid),
        .i_itt_event_bits (i_itt_event_bits),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_out_stall      (i_out_stall),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_out_intid      (o_out_intid),
        .o_out_target     (o_out_target)
    );

    // One transaction at a time: the lookup chain holds off the next one
    `MSITS_ASSERT_NEXT(a_accept_then_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input accepted during a lookup")
    // A failed or non-translate result carries no intid or target
    `MSITS_ASSERT_SAME(a_error_fields_zero, i_clk, i_rst_n, o_out_valid && (o_status != STS_OK), (o_out_intid == 16'd0) && (o_out_target == 16'd0), "nonzero payload with error status")
    `MSITS_ASSERT_SAME(a_status_range, i_clk, i_rst_n, o_out_valid, o_status <= STS_BADOP, "status code out of range")

endmodule

`default_nettype wire
